[rtl/core/swsh_pkg.sv]
package swsh_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned LenW   = 32;
  localparam int unsigned SeedW  = 32;
  localparam int unsigned AccW   = 128;
  localparam int unsigned LimbW  = 32;
  localparam int unsigned StepW  = 3;
  localparam int unsigned MixShift = 29;

  localparam logic [StepW-1:0] LastStep = 3'd7;

  localparam logic [WordW-1:0] K_TABLE [16] = '{
    64'hb7e151628aed2a6a, 64'hbf7158809cf4f3c7,
    64'h62e7160f38b4da56, 64'ha784d9045190cfef,
    64'h324e7738926cfbe5, 64'hf4bf8d8d8c31d763,
    64'hda06c80abb1185eb, 64'h4f7c7b5757f59584,
    64'h90cfd47d7c19bb42, 64'h158d9554f7b46bce,
    64'hd55c4d79fd5f24d6, 64'h613c31c3839a2ddf,
    64'h8a9a276bcfbfa1c8, 64'h77c56284dab79cd4,
    64'hc2b3293d20e9e5ea, 64'hf02ac60acc93ed87
  };

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_MUL1,
    ST_MIX,
    ST_MUL2,
    ST_EMIT
  } state_e;

  // One partial product of the 128x64 multiply, truncated to 128 bits
  typedef struct packed {
    logic [1:0] acc_limb;
    logic       k_limb;
    logic [1:0] shift;
  } mul_sel_t;

  typedef struct packed {
    logic             accept;
    logic             mul_step;
    logic [StepW-1:0] mul_idx;
    logic             mul_last;
    logic             mix;
    logic             out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic msg_last;
    logic out_free;
  } dp_status_t;

  function automatic mul_sel_t mul_sel(input logic [StepW-1:0] idx);
    mul_sel_t s;
    unique case (idx)
      3'd0:    s = '{acc_limb: 2'd0, k_limb: 1'b0, shift: 2'd0};
      3'd1:    s = '{acc_limb: 2'd1, k_limb: 1'b0, shift: 2'd1};
      3'd2:    s = '{acc_limb: 2'd2, k_limb: 1'b0, shift: 2'd2};
      3'd3:    s = '{acc_limb: 2'd3, k_limb: 1'b0, shift: 2'd3};
      3'd4:    s = '{acc_limb: 2'd0, k_limb: 1'b1, shift: 2'd1};
      3'd5:    s = '{acc_limb: 2'd1, k_limb: 1'b1, shift: 2'd2};
      3'd6:    s = '{acc_limb: 2'd2, k_limb: 1'b1, shift: 2'd3};
      default: s = '{acc_limb: 2'd0, k_limb: 1'b0, shift: 2'd0};
    endcase
    return s;
  endfunction

endpackage

[rtl/core/swsh_ctrl.sv]
module swsh_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  swsh_pkg::dp_status_t status_i,
  output swsh_pkg::dp_cmd_t    cmd_o
);

  swsh_pkg::state_e state_q, state_d;
  logic [swsh_pkg::StepW-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swsh_pkg::ST_ACCUM;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    in_stall_o   = 1'b1;
    cmd_o        = '0;
    cmd_o.mul_idx = step_q;
    cmd_o.mul_last = (step_q == swsh_pkg::LastStep);
    unique case (state_q)
      swsh_pkg::ST_ACCUM: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        step_d       = '0;
        if (in_valid_i && status_i.msg_last) begin
          state_d = swsh_pkg::ST_MUL1;
        end
      end
      swsh_pkg::ST_MUL1: begin
        cmd_o.mul_step = 1'b1;
        step_d = step_q + swsh_pkg::StepW'(1);
        if (step_q == swsh_pkg::LastStep) begin
          state_d = swsh_pkg::ST_MIX;
        end
      end
      swsh_pkg::ST_MIX: begin
        cmd_o.mix = 1'b1;
        state_d   = swsh_pkg::ST_MUL2;
      end
      swsh_pkg::ST_MUL2: begin
        cmd_o.mul_step = 1'b1;
        step_d = step_q + swsh_pkg::StepW'(1);
        if (step_q == swsh_pkg::LastStep) begin
          state_d = swsh_pkg::ST_EMIT;
        end
      end
      swsh_pkg::ST_EMIT: begin
        // hold until the output register can take the hash
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = swsh_pkg::ST_ACCUM;
        end
      end
      default: begin
        state_d = swsh_pkg::ST_ACCUM;
      end
    endcase
  end

endmodule

[rtl/core/swsh_dp.sv]
module swsh_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [swsh_pkg::SeedW-1:0]    cfg_wdata_i,
  input  logic [swsh_pkg::WordW-1:0]    data_word_i,
  input  logic [swsh_pkg::LenW-1:0]     message_length_i,
  output logic [swsh_pkg::WordW-1:0]    hash_value_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  swsh_pkg::dp_cmd_t             cmd_i,
  output swsh_pkg::dp_status_t          status_o
);

  logic [swsh_pkg::SeedW-1:0] seed_q;
  logic [swsh_pkg::AccW-1:0]  acc_q, sum_q;
  logic [swsh_pkg::LenW-1:0]  rem_q;
  logic                       in_msg_q;
  logic [2*swsh_pkg::LimbW-1:0] prod_q, prod_d;
  logic [1:0]                 prod_sh_q;
  logic [swsh_pkg::WordW-1:0] hash_q;
  logic                       out_valid_q;

  logic [swsh_pkg::LenW-1:0]  rem_eff;
  logic [swsh_pkg::AccW-1:0]  acc_base, acc_add, sum_add, mix_val;
  logic [swsh_pkg::WordW-1:0] word_masked, k_word;
  logic [swsh_pkg::LimbW-1:0] a_limb, k_limb;
  logic                       msg_last;
  swsh_pkg::mul_sel_t         sel;

  assign rem_eff  = in_msg_q ? rem_q : message_length_i;
  assign msg_last = (rem_eff <= swsh_pkg::LenW'(8));
  assign acc_base = in_msg_q ? acc_q
                  : {64'd0, swsh_pkg::K_TABLE[0] ^ {seed_q, message_length_i}};

  // keep only the bytes still owed by the message
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      word_masked[8*b +: 8] = (rem_eff > swsh_pkg::LenW'(b)) ? data_word_i[8*b +: 8] : 8'd0;
    end
  end

  assign acc_add = acc_base + {64'd0, word_masked};
  assign mix_val = acc_q ^ (acc_q >> swsh_pkg::MixShift);

  assign sel     = swsh_pkg::mul_sel(cmd_i.mul_idx);
  assign k_word  = swsh_pkg::K_TABLE[acc_q[3:0]];
  assign a_limb  = acc_q[swsh_pkg::LimbW*sel.acc_limb +: swsh_pkg::LimbW];
  assign k_limb  = sel.k_limb ? k_word[63:32] : k_word[31:0];
  assign prod_d  = {32'd0, a_limb} * {32'd0, k_limb};
  assign sum_add = sum_q + ({64'd0, prod_q} << {prod_sh_q, 5'd0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= '0;
      rem_q       <= '0;
      in_msg_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        rem_q    <= rem_eff - swsh_pkg::LenW'(8);
        in_msg_q <= !msg_last;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      acc_q <= acc_add;
    end else if (cmd_i.mix) begin
      acc_q <= mix_val;
    end else if (cmd_i.mul_step && cmd_i.mul_last) begin
      acc_q <= sum_add;
    end
    if (cmd_i.mul_step) begin
      prod_q    <= prod_d;
      prod_sh_q <= sel.shift;
      // first step has no product in flight yet
      sum_q <= (cmd_i.mul_idx == '0) ? '0 : sum_add;
    end
    if (cmd_i.out_load) begin
      hash_q <= acc_q[127:64] + acc_q[63:0];
    end
  end

  assign status_o.msg_last = msg_last;
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign hash_value_o      = hash_q;
  assign out_valid_o       = out_valid_q;

endmodule

[rtl/core/seeded_word_sum_hash64.sv]
// Seeded word-sum hash with a 64-bit result.
// Input channel: in_valid_i / in_stall_o with data_word_i and message_length_i.
// The first word of a message carries the byte length; a zero-length message
// is a single transfer whose data is ignored. Upper bytes of the last word
// beyond the length are dropped.
// Output channel: out_valid_o / out_stall_i with hash_value_o, one result per
// message, held in an output register until the receiver takes it.
// Configuration: cfg_we_i writes cfg_wdata_i to the seed; the seed is sampled
// on the first word of each message.
// Throughput: one word per cycle within a message. The final word starts a
// finalizer of two 128x64 multiplies, each eight steps of one shared 32x32
// multiplier, with a mix step between; the input stays stalled after the final
// word until the hash is loaded into the output register, which raises out_valid_o.
// A stalled receiver holds the hash; a following message may stream in, and
// its finalizer waits only if the previous hash has not been taken yet.
// Reset clears the message state, the seed and the output valid.
module seeded_word_sum_hash64 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] data_word_i,
  input  logic [31:0] message_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_value_o
);

  swsh_pkg::dp_cmd_t    cmd;
  swsh_pkg::dp_status_t status;

  swsh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  swsh_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .data_word_i      (data_word_i),
    .message_length_i (message_length_i),
    .hash_value_o     (hash_value_o),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .cmd_i            (cmd),
    .status_o         (status)
  );

endmodule

[tb/sv/tb_seeded_word_sum_hash64.sv]
module tb_seeded_word_sum_hash64;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CHOKE_CYCLES = 400;
  localparam int unsigned PHASE_WORDS  = 90;

  localparam logic [63:0] MIX_K [16] = '{
    64'hb7e151628aed2a6a, 64'hbf7158809cf4f3c7,
    64'h62e7160f38b4da56, 64'ha784d9045190cfef,
    64'h324e7738926cfbe5, 64'hf4bf8d8d8c31d763,
    64'hda06c80abb1185eb, 64'h4f7c7b5757f59584,
    64'h90cfd47d7c19bb42, 64'h158d9554f7b46bce,
    64'hd55c4d79fd5f24d6, 64'h613c31c3839a2ddf,
    64'h8a9a276bcfbfa1c8, 64'h77c56284dab79cd4,
    64'hc2b3293d20e9e5ea, 64'hf02ac60acc93ed87
  };

  localparam logic [31:0] PHASE_SEEDS [6] = '{
    32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0001,
    32'h5a5a_a5a5, 32'h7fff_ffff
  };

  typedef enum int {FILL_MIX, FILL_ONES, FILL_ZERO} fill_e;

  typedef struct packed {
    logic [63:0] word;
    logic [31:0] len;
  } word_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] data_word = '0;
  logic [31:0] message_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] hash_value;

  seeded_word_sum_hash64 dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .data_word_i     (data_word),
    .message_length_i(message_length),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .hash_value_o    (hash_value)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor state
  logic [127:0] acc_st = '0;
  logic [31:0]  left_st = '0;
  logic         msg_open = 1'b0;
  logic [31:0]  seed_copy = '0;
  logic [63:0]  hash_q [$];

  word_item_t  word_q [$];
  int unsigned words_queued = 0;
  int unsigned words_taken = 0;
  int unsigned miss_count = 0;
  int unsigned in_wait = 0;
  int unsigned out_wait = 0;
  int unsigned choke_left = 0;
  int unsigned idle_cycles = 0;
  bit          in_calm = 1'b1;
  bit          out_calm = 1'b1;
  bit          choke_req = 1'b0;
  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;

  function automatic int unsigned draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic [63:0] finish_hash(logic [127:0] a);
    a = a * {64'd0, MIX_K[a[3:0]]};
    a = a ^ (a >> 29);
    a = a * {64'd0, MIX_K[a[3:0]]};
    return a[127:64] + a[63:0];
  endfunction

  task automatic absorb_word(logic [63:0] w, logic [31:0] len);
    logic [31:0] take;
    if (!msg_open) begin
      acc_st = {64'd0, MIX_K[0] ^ {seed_copy, 32'd0} ^ {32'd0, len}};
      // empty message: data ignored, hash right away
      if (len == 0) begin
        hash_q.push_back(finish_hash(acc_st));
        return;
      end
      left_st = len;
      msg_open = 1'b1;
    end
    take = (left_st < 8) ? left_st : 32'd8;
    // drop the bytes past the end of the message
    if (take < 8) w &= (64'd1 << (take * 8)) - 64'd1;
    acc_st += {64'd0, w};
    left_st -= take;
    if (left_st == 0) begin
      msg_open = 1'b0;
      hash_q.push_back(finish_hash(acc_st));
    end
  endtask

  task automatic flag_miss(bit stray, logic [63:0] want, logic [63:0] got);
    if (miss_count < 10) begin
      if (stray) $display("unexpected hash %h at %0t", got, $realtime);
      else $display("hash mismatch at %0t: expected %h, got %h", $realtime, want, got);
    end
    miss_count++;
  endtask

  // Input side: predict on every transfer
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      absorb_word(data_word, message_length);
      words_taken++;
    end
  end

  always @(negedge clk) begin
    logic       nxt;
    word_item_t it;
    nxt = in_valid && !in_fire;
    if (rst_n && !nxt) begin
      if (in_wait > 0) begin
        in_wait--;
      end else if (word_q.size() > 0) begin
        it = word_q.pop_front();
        data_word <= it.word;
        message_length <= it.len;
        nxt = 1'b1;
        in_wait = draw_gap(in_calm);
      end
    end
    in_valid <= nxt;
  end

  // Output side: check every transfer against the oldest expected hash
  always @(posedge clk) begin
    logic [63:0] want;
    out_fire <= rst_n && out_valid && !out_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (hash_q.size() == 0) begin
        flag_miss(1'b1, '0, hash_value);
      end else begin
        want = hash_q.pop_front();
        if (want !== hash_value) flag_miss(1'b0, want, hash_value);
      end
    end
  end

  always @(negedge clk) begin
    if (choke_req) begin
      choke_left = CHOKE_CYCLES;
      choke_req = 1'b0;
    end
    if (out_fire) out_wait = draw_gap(out_calm);
    out_stall <= (choke_left > 0) || (out_wait > 0);
    if (choke_left > 0) choke_left--;
    else if (out_valid && out_wait > 0) out_wait--;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic queue_message(logic [31:0] len, fill_e fill, int unsigned cap);
    int unsigned n;
    word_item_t  it;
    n = len / 8 + ((len % 8) != 0);
    if (n == 0) n = 1;
    if (cap != 0 && n > cap) n = cap;
    for (int unsigned i = 0; i < n; i++) begin
      case (fill)
        FILL_ONES: it.word = '1;
        FILL_ZERO: it.word = '0;
        default: begin
          case ($urandom_range(0, 9))
            0:       it.word = '1;
            1:       it.word = '0;
            default: it.word = {$urandom, $urandom};
          endcase
        end
      endcase
      // length is ignored past the first word, so fill it with noise
      it.len = (i == 0) ? len : $urandom;
      word_q.push_back(it);
      words_queued++;
    end
  endtask

  task automatic write_seed(logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    seed_copy = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (words_taken != words_queued || hash_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int unsigned target;
    logic [31:0] len;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // directed: empty, short, exact word, partial tails, carries, reset seed
    queue_message(32'd0, FILL_ONES, 0);
    queue_message(32'd0, FILL_ZERO, 0);
    queue_message(32'd1, FILL_ONES, 0);
    queue_message(32'd7, FILL_ONES, 0);
    queue_message(32'd8, FILL_ONES, 0);
    queue_message(32'd9, FILL_ONES, 0);
    queue_message(32'd15, FILL_ONES, 0);
    queue_message(32'd16, FILL_ONES, 0);
    queue_message(32'd3, FILL_ZERO, 0);
    settle();
    write_seed(32'hffff_ffff);
    queue_message(32'd0, FILL_ONES, 0);
    queue_message(32'd8, FILL_ONES, 0);
    queue_message(32'd13, FILL_ONES, 0);
    queue_message(32'd24, FILL_MIX, 0);
    settle();

    for (int p = 0; p < 6; p++) begin
      write_seed((p == 4) ? $urandom : PHASE_SEEDS[p]);
      in_calm = (p == 1);
      out_calm = (p == 2);
      if (p == 3) begin
        // hold off the receiver so the block backs up into its input
        @(posedge clk);
        choke_req = 1'b1;
      end
      target = words_queued + PHASE_WORDS;
      while (words_queued < target) begin
        case ($urandom_range(0, 19))
          0, 1, 2:             len = $urandom_range(0, 8);
          3, 4, 5, 6, 7, 8,
          9, 10, 11, 12, 13,
          14:                  len = $urandom_range(9, 64);
          15, 16, 17, 18:      len = $urandom_range(65, 256);
          default:             len = $urandom_range(257, 1024);
        endcase
        queue_message(len, FILL_MIX, 0);
      end
      settle();
    end

    // a message of the largest length: open it and feed a few words only
    in_calm = 1'b0;
    out_calm = 1'b0;
    queue_message(32'hffff_ffff, FILL_MIX, 24);
    settle();

    if (miss_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
